// ----- rtl/gdsc_pkg.sv -----
// package: shared types, constants and lookup functions for the day span counter
`timescale 1ns / 1ps

package gdsc_pkg;

  localparam int DATE_W  = 27;
  localparam int COUNT_W = 22;

  typedef logic [DATE_W-1:0]  date_t;
  typedef logic [COUNT_W-1:0] day_num_t;

  // one date unit has seven register stages, the compare stage makes eight
  localparam int UNIT_STAGES = 7;
  localparam int PIPE_STAGES = UNIT_STAGES + 1;

  localparam int DAY_DIV   = 1000000;
  localparam int MONTH_DIV = 10000;
  localparam int CENT_DIV  = 100;
  localparam int YEAR_BIAS = 400;
  localparam int DAYS_YEAR = 365;

  // reciprocal constants, rounded up, exact over the input ranges used
  localparam int DAY_SHIFT   = 47;
  localparam int MONTH_SHIFT = 34;
  localparam int CENT_SHIFT  = 20;

  localparam logic [27:0] DAY_MAGIC =
    28'(((64'd1 << DAY_SHIFT) + 64'(DAY_DIV) - 64'd1) / 64'(DAY_DIV));
  localparam logic [20:0] MONTH_MAGIC =
    21'(((64'd1 << MONTH_SHIFT) + 64'(MONTH_DIV) - 64'd1) / 64'(MONTH_DIV));
  localparam logic [13:0] CENT_MAGIC =
    14'(((64'd1 << CENT_SHIFT) + 64'(CENT_DIV) - 64'd1) / 64'(CENT_DIV));

  localparam logic [6:0] MONTH_FEB = 7'd2;
  localparam logic [6:0] MONTH_DEC = 7'd12;

  function automatic logic [4:0] month_len(input logic [6:0] m, input logic leap);
    logic [4:0] len;
    case (m) inside
      MONTH_FEB:                  len = leap ? 5'd29 : 5'd28;
      7'd4, 7'd6, 7'd9, 7'd11:    len = 5'd30;
      default:                    len = 5'd31;
    endcase
    return len;
  endfunction

  // days before the first of a march-based month
  function automatic logic [8:0] month_offset(input logic [3:0] mp);
    logic [8:0] off;
    case (mp)
      4'd0:    off = 9'd0;
      4'd1:    off = 9'd31;
      4'd2:    off = 9'd61;
      4'd3:    off = 9'd92;
      4'd4:    off = 9'd122;
      4'd5:    off = 9'd153;
      4'd6:    off = 9'd184;
      4'd7:    off = 9'd214;
      4'd8:    off = 9'd245;
      4'd9:    off = 9'd275;
      4'd10:   off = 9'd306;
      4'd11:   off = 9'd337;
      default: off = 9'd0;
    endcase
    return off;
  endfunction

endpackage

// ----- rtl/gdsc_date_unit.sv -----
// date unit: splits a packed date, checks it and forms its serial day number
`timescale 1ns / 1ps

module gdsc_date_unit (
  input  logic                                clk,
  input  logic [gdsc_pkg::UNIT_STAGES-1:0]    stage_en,
  input  gdsc_pkg::date_t                     date,
  output gdsc_pkg::day_num_t                  day_num,
  output logic                                date_ok
);

  // stage 1
  logic [54:0] prod1;
  logic [26:0] x1_r;
  logic [7:0]  qd1_r;
  // stage 2
  logic [19:0] r2_nxt;
  logic [7:0]  d2_r;
  logic [19:0] r2_r;
  // stage 3
  logic [40:0] prod3;
  logic [7:0]  d3_r;
  logic [19:0] r3_r;
  logic [6:0]  qm3_r;
  // stage 4
  logic [13:0] y4_nxt;
  logic [7:0]  d4_r;
  logic [6:0]  m4_r;
  logic [13:0] y4_r;
  // stage 5
  logic [27:0] prod5;
  logic        early;
  logic [13:0] yy5_nxt;
  logic [3:0]  mp5_nxt;
  logic [7:0]  d5_r;
  logic [6:0]  m5_r;
  logic [13:0] y5_r;
  logic [6:0]  cy5_r;
  logic [13:0] yy5_r;
  logic [3:0]  mp5_r;
  // stage 6
  logic [27:0] prod6;
  logic        cent_even;
  logic        leap;
  logic [4:0]  mlen;
  logic        ok6_nxt;
  logic [7:0]  d6_r;
  logic [13:0] yy6_r;
  logic [6:0]  cyy6_r;
  logic [8:0]  moff6_r;
  logic        ok6_r;
  // stage 7
  logic [21:0] dn7_nxt;
  logic [21:0] dn7_r;
  logic        ok7_r;

  assign prod1 = 55'(date) * 55'(gdsc_pkg::DAY_MAGIC);

  assign r2_nxt = 20'(x1_r - 27'(qd1_r) * 27'(gdsc_pkg::DAY_DIV));

  assign prod3 = 41'(r2_r) * 41'(gdsc_pkg::MONTH_MAGIC);

  assign y4_nxt = 14'(r3_r - 20'(qm3_r) * 20'(gdsc_pkg::MONTH_DIV));

  // january and february count as the end of the previous year
  assign prod5   = 28'(y4_r) * 28'(gdsc_pkg::CENT_MAGIC);
  assign early   = (m4_r <= gdsc_pkg::MONTH_FEB);
  assign yy5_nxt = y4_r + 14'(gdsc_pkg::YEAR_BIAS) - 14'(early);
  assign mp5_nxt = early ? 4'(m4_r + 7'd9) : 4'(m4_r - 7'd3);

  assign prod6     = 28'(yy5_r) * 28'(gdsc_pkg::CENT_MAGIC);
  assign cent_even = (y5_r == 14'(cy5_r) * 14'(gdsc_pkg::CENT_DIV));
  assign leap      = ((y5_r[1:0] == 2'b00) && !cent_even) ||
                     (cent_even && (cy5_r[1:0] == 2'b00));
  assign mlen      = gdsc_pkg::month_len(m5_r, leap);
  assign ok6_nxt   = (m5_r != 7'd0) && (m5_r <= gdsc_pkg::MONTH_DEC) &&
                     (d5_r != 8'd0) && (d5_r <= 8'(mlen));

  assign dn7_nxt = 22'(yy6_r) * 22'(gdsc_pkg::DAYS_YEAR)
                 + 22'(yy6_r[13:2])
                 - 22'(cyy6_r)
                 + 22'(cyy6_r[6:2])
                 + 22'(moff6_r)
                 + 22'(d6_r);

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      x1_r  <= date;
      qd1_r <= prod1[gdsc_pkg::DAY_SHIFT +: 8];
    end
    if (stage_en[1]) begin
      d2_r <= qd1_r;
      r2_r <= r2_nxt;
    end
    if (stage_en[2]) begin
      d3_r  <= d2_r;
      r3_r  <= r2_r;
      qm3_r <= prod3[gdsc_pkg::MONTH_SHIFT +: 7];
    end
    if (stage_en[3]) begin
      d4_r <= d3_r;
      m4_r <= qm3_r;
      y4_r <= y4_nxt;
    end
    if (stage_en[4]) begin
      d5_r  <= d4_r;
      m5_r  <= m4_r;
      y5_r  <= y4_r;
      cy5_r <= prod5[gdsc_pkg::CENT_SHIFT +: 7];
      yy5_r <= yy5_nxt;
      mp5_r <= mp5_nxt;
    end
    if (stage_en[5]) begin
      d6_r    <= d5_r;
      yy6_r   <= yy5_r;
      cyy6_r  <= prod6[gdsc_pkg::CENT_SHIFT +: 7];
      moff6_r <= gdsc_pkg::month_offset(mp5_r);
      ok6_r   <= ok6_nxt;
    end
    if (stage_en[6]) begin
      dn7_r <= dn7_nxt;
      ok7_r <= ok6_r;
    end
  end

  assign day_num = dn7_r;
  assign date_ok = ok7_r;

endmodule

// ----- rtl/gregorian_day_span_counter.sv -----
// top level: inclusive day count between two packed gregorian dates
`timescale 1ns / 1ps

// channel  dir  handshake            payload
// in       in   in_valid/in_ready    in_start_date[26:0], in_end_date[26:0]
// out      out  out_valid/out_ready  out_day_count[21:0], out_date_error
//
// one item per cycle sustained while the output is not stalled
// results pass through eight register stages: seven per date unit, one compare
// each stage holds while the next is full and stalled; bubbles close up
// reset empties every stage, the payload registers are not cleared

module gregorian_day_span_counter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [26:0] in_start_date,
  input  logic [26:0] in_end_date,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [21:0] out_day_count,
  output logic        out_date_error
);

  localparam int NST = gdsc_pkg::PIPE_STAGES;

  logic [NST-1:0]     v_r;
  logic [NST-1:0]     v_nxt;
  logic [NST-1:0]     en;
  gdsc_pkg::day_num_t dn_start;
  gdsc_pkg::day_num_t dn_end;
  logic               ok_start;
  logic               ok_end;
  logic [21:0]        count_nxt;
  logic [21:0]        count_r;
  logic               err_r;

  always_comb begin
    en[NST-1] = !v_r[NST-1] || out_ready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
    v_nxt[0] = en[0] ? in_valid : v_r[0];
    for (int k = 1; k < NST; k++) begin
      v_nxt[k] = en[k] ? v_r[k-1] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  gdsc_date_unit u_start (
    .clk      (clk),
    .stage_en (en[NST-2:0]),
    .date     (in_start_date),
    .day_num  (dn_start),
    .date_ok  (ok_start)
  );

  gdsc_date_unit u_end (
    .clk      (clk),
    .stage_en (en[NST-2:0]),
    .date     (in_end_date),
    .day_num  (dn_end),
    .date_ok  (ok_end)
  );

  always_comb begin
    count_nxt = '0;
    if (ok_start && ok_end && (dn_end >= dn_start)) begin
      count_nxt = dn_end - dn_start + 22'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (en[NST-1]) begin
      count_r <= count_nxt;
      err_r   <= !(ok_start && ok_end);
    end
  end

  assign in_ready       = en[0];
  assign out_valid      = v_r[NST-1];
  assign out_day_count  = count_r;
  assign out_date_error = err_r;

`ifndef NO_ASSERTIONS
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_date_error |-> out_day_count == 22'd0)
    else $error("day count not zero on a date error");

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_day_count <= 22'd3652425)
    else $error("day count beyond the widest span");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> v_r[0])
    else $error("accepted item missing from the first stage");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (&v_r) && !out_ready |-> !in_ready)
    else $error("item taken while the pipeline is full and stalled");
`endif

endmodule
